### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

### src/sdtq_pkg.sv
// ----------------------------------------------------------------------------
// sdtq_pkg
// shared constants, request kinds and controller/datapath interface types
// ----------------------------------------------------------------------------
package sdtq_pkg;

  localparam int NUM_FDS   = 32;
  localparam int TIME_BITS = 32;
  localparam int FD_W      = 5;
  localparam int KIND_W    = 2;
  localparam int IN_TIME_W = 32;
  localparam int SLOT_W    = $clog2(NUM_FDS);
  localparam int CNT_W     = $clog2(NUM_FDS + 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD  = 2'd0,
    KIND_DEL  = 2'd1,
    KIND_TICK = 2'd2
  } kind_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic find;
    logic remove;
    logic compare;
    logic insert;
    logic pop;
  } sdtq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fd_ok;
    logic active;
    logic full;
    logic head_due;
    logic next_due;
    logic out_free;
  } sdtq_status_t;

endpackage

### src/sdtq_ctrl.sv
// ----------------------------------------------------------------------------
// sdtq_ctrl
// sequencer for add, delete and tick requests
// ----------------------------------------------------------------------------
module sdtq_ctrl import sdtq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [KIND_W-1:0]  in_kind_i,
  input  logic               add_q_i,
  input  sdtq_status_t       status_i,
  output logic               stall_o,
  output sdtq_cmd_t          cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_REMOVE,
    ST_CMP,
    ST_INSERT,
    ST_DRAIN
  } state_e;

  state_e state_q;
  state_e state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          case (kind_e'(in_kind_i))
            KIND_ADD:  state_d = ST_FIND;
            KIND_DEL:  state_d = ST_FIND;
            KIND_TICK: state_d = ST_DRAIN;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_FIND: begin
        cmd_o.find = 1'b1;
        if (!status_i.fd_ok) begin
          state_d = ST_IDLE;
        end else if (status_i.active) begin
          state_d = ST_REMOVE;
        end else if (add_q_i) begin
          state_d = ST_CMP;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_REMOVE: begin
        cmd_o.remove = 1'b1;
        state_d      = add_q_i ? ST_CMP : ST_IDLE;
      end
      ST_CMP: begin
        cmd_o.compare = 1'b1;
        state_d       = ST_INSERT;
      end
      ST_INSERT: begin
        cmd_o.insert = !status_i.full;
        state_d      = ST_IDLE;
      end
      ST_DRAIN: begin
        // pop one due entry per cycle while the output register has room
        if (!status_i.head_due) begin
          state_d = ST_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.pop = 1'b1;
          if (!status_i.next_due) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign stall_o = (state_q != ST_IDLE);

endmodule

### src/sdtq_datapath.sv
// ----------------------------------------------------------------------------
// sdtq_datapath
// sorted slot registers, descriptor flags and output register
// ----------------------------------------------------------------------------
module sdtq_datapath import sdtq_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sdtq_cmd_t             cmd_i,
  input  logic [KIND_W-1:0]     in_kind_i,
  input  logic [FD_W-1:0]       in_fd_number_i,
  input  logic [IN_TIME_W-1:0]  in_time_value_i,
  input  logic                  out_stall_i,
  output logic                  add_q_o,
  output sdtq_status_t          status_o,
  output logic                  out_valid_o,
  output logic [FD_W-1:0]       out_expired_fd_o,
  output logic                  out_last_o
);

  logic                 add_q;
  logic [FD_W-1:0]      fd_q;
  logic [TIME_BITS-1:0] time_q;

  logic [FD_W-1:0]      slot_fd_q [NUM_FDS];
  logic [TIME_BITS-1:0] slot_dl_q [NUM_FDS];
  logic [CNT_W-1:0]     count_q;
  logic [NUM_FDS-1:0]   active_q;
  logic [SLOT_W-1:0]    del_idx_q;
  logic [NUM_FDS-1:0]   keep_q;

  logic                 out_valid_q;
  logic [FD_W-1:0]      out_fd_q;
  logic                 out_last_q;

  logic [SLOT_W-1:0]    fd_idx;
  logic [SLOT_W-1:0]    match_idx;
  logic [SLOT_W-1:0]    shift_idx;
  logic [NUM_FDS-1:0]   keep_d;
  logic [NUM_FDS-1:0]   ins_here;
  logic                 full;
  logic                 head_due;
  logic                 next_due;
  logic                 out_free;
  logic                 shift_dn;

  assign fd_idx    = SLOT_W'(fd_q);
  assign full      = (count_q == CNT_W'(NUM_FDS));
  assign head_due  = (count_q != '0) && (slot_dl_q[0] <= time_q);
  assign next_due  = (count_q > CNT_W'(1)) && (slot_dl_q[1] <= time_q);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign shift_dn  = cmd_i.remove || cmd_i.pop;
  assign shift_idx = cmd_i.pop ? '0 : del_idx_q;

  // descriptor is unique in the list, so or-ing indexes encodes the one-hot match
  always_comb begin
    match_idx = '0;
    for (int i = 0; i < NUM_FDS; i++) begin
      if ((CNT_W'(i) < count_q) && (slot_fd_q[i] == fd_q)) begin
        match_idx = match_idx | SLOT_W'(i);
      end
    end
  end

  // sorted list makes keep a prefix mask of entries at or before the deadline
  always_comb begin
    for (int i = 0; i < NUM_FDS; i++) begin
      keep_d[i] = (CNT_W'(i) < count_q) && (slot_dl_q[i] <= time_q);
    end
    ins_here[0] = !keep_q[0];
    for (int i = 1; i < NUM_FDS; i++) begin
      ins_here[i] = keep_q[i-1] && !keep_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      add_q  <= (kind_e'(in_kind_i) == KIND_ADD);
      fd_q   <= in_fd_number_i;
      time_q <= TIME_BITS'(in_time_value_i);
    end
    if (cmd_i.find) begin
      del_idx_q <= match_idx;
    end
    if (cmd_i.compare) begin
      keep_q <= keep_d;
    end
    if (cmd_i.pop) begin
      out_fd_q   <= slot_fd_q[0];
      out_last_q <= !next_due;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_dn) begin
      for (int i = 0; i < NUM_FDS - 1; i++) begin
        if (SLOT_W'(i) >= shift_idx) begin
          slot_fd_q[i] <= slot_fd_q[i+1];
          slot_dl_q[i] <= slot_dl_q[i+1];
        end
      end
    end else if (cmd_i.insert) begin
      if (ins_here[0]) begin
        slot_fd_q[0] <= fd_q;
        slot_dl_q[0] <= time_q;
      end
      for (int i = 1; i < NUM_FDS; i++) begin
        if (ins_here[i]) begin
          slot_fd_q[i] <= fd_q;
          slot_dl_q[i] <= time_q;
        end else if (!keep_q[i-1]) begin
          slot_fd_q[i] <= slot_fd_q[i-1];
          slot_dl_q[i] <= slot_dl_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      active_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (shift_dn) begin
        count_q <= count_q - CNT_W'(1);
      end else if (cmd_i.insert) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (cmd_i.remove) begin
        active_q[fd_idx] <= 1'b0;
      end else if (cmd_i.pop) begin
        active_q[SLOT_W'(slot_fd_q[0])] <= 1'b0;
      end else if (cmd_i.insert) begin
        active_q[fd_idx] <= 1'b1;
      end
      if (cmd_i.pop) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign add_q_o           = add_q;
  assign status_o.fd_ok    = (32'(fd_q) < NUM_FDS);
  assign status_o.active   = active_q[fd_idx];
  assign status_o.full     = full;
  assign status_o.head_due = head_due;
  assign status_o.next_due = next_due;
  assign status_o.out_free = out_free;

  assign out_valid_o      = out_valid_q;
  assign out_expired_fd_o = out_fd_q;
  assign out_last_o       = out_last_q;

endmodule

### src/sorted_deadline_timer_queue_core.sv
// ----------------------------------------------------------------------------
// sorted_deadline_timer_queue_core
// deadline-ordered timer list, one timer per descriptor
// ----------------------------------------------------------------------------
// Keeps up to 32 timers in a register list sorted by deadline, ties in order
// of arrival. An add of an already queued descriptor replaces its deadline;
// a delete of an idle descriptor and requests of kind 3 do nothing. A tick
// pops every entry due at or before its time, one result a cycle while
// the output register has room, last set on the final one, and gives
// nothing if none is due. The block takes one request at a time: a delete
// steps through find and, if the descriptor is queued, remove; an add
// then goes on to compare and insert; a tick drains. Results sit in an
// output register, so a new request is taken while one waits.
`include "assert_macros.svh"

module sorted_deadline_timer_queue_core import sdtq_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [KIND_W-1:0]     in_kind_i,
  input  logic [FD_W-1:0]       in_fd_number_i,
  input  logic [IN_TIME_W-1:0]  in_time_value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [FD_W-1:0]       out_expired_fd_o,
  output logic                  out_last_o
);

  sdtq_cmd_t    cmd;
  sdtq_status_t status;
  logic         add_q;

  sdtq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (in_kind_i),
    .add_q_i    (add_q),
    .status_i   (status),
    .stall_o    (in_stall_o),
    .cmd_o      (cmd)
  );

  sdtq_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .in_kind_i        (in_kind_i),
    .in_fd_number_i   (in_fd_number_i),
    .in_time_value_i  (in_time_value_i),
    .out_stall_i      (out_stall_i),
    .add_q_o          (add_q),
    .status_o         (status),
    .out_valid_o      (out_valid_o),
    .out_expired_fd_o (out_expired_fd_o),
    .out_last_o       (out_last_o)
  );

  `ASSERT_NEVER(a_pop_needs_room, clk_i, rst_ni, cmd.pop && !status.out_free, "pop without output room")
  `ASSERT_PROP(a_pop_only_due, clk_i, rst_ni, cmd.pop |-> status.head_due, "pop of entry not due")
  `ASSERT_NEVER(a_insert_full, clk_i, rst_ni, cmd.insert && status.full, "insert into full list")
  `ASSERT_PROP(a_pop_sets_valid, clk_i, rst_ni, cmd.pop |=> out_valid_o, "popped result not shown")

endmodule
